[rtl/annexb_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes for the annex b start code splitter
package annexb_pkg;

  localparam logic       OP_BYTE       = 1'b0;
  localparam logic       OP_EOS        = 1'b1;

  localparam logic       ST_UNIT       = 1'b0;
  localparam logic       ST_BAD_PREFIX = 1'b1;

  localparam logic [2:0] SC_NONE       = 3'd0;
  localparam logic [2:0] SC_SHORT      = 3'd3;
  localparam logic [2:0] SC_LONG       = 3'd4;

  localparam logic [7:0] START_BYTE    = 8'h01;
  localparam int unsigned LEN_W        = 17;
  localparam logic [LEN_W-1:0] BAD_PREFIX_LEN = 17'd4;
  localparam int unsigned MIN_LIMIT    = 5;

  localparam logic [1:0] PC_FIRST      = 2'd0;
  localparam logic [1:0] PC_SHORT_CHK  = 2'd2;
  localparam logic [1:0] PC_LONG_CHK   = 2'd3;

  typedef struct packed {
    logic             status;
    logic [LEN_W-1:0] unit_length;
    logic [2:0]       start_code_length;
    logic             header_present;
    logic             f_bit;
    logic [1:0]       reference_idc;
    logic [4:0]       unit_type;
    logic             length_overflow;
  } result_t;

endpackage

[rtl/annexb_parser.sv]
`timescale 1ns / 1ps
// start code search, unit length count and header capture for one item per cycle while step_i is high
module annexb_parser import annexb_pkg::*; #(
  parameter int unsigned MAX_UNIT_BYTES = 65536
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic                                  operation_i,
  input  logic [7:0]                            data_byte_i,
  input  logic [$clog2(MAX_UNIT_BYTES+5)-1:0]   limit_i,
  output logic                                  res_valid_o,
  output result_t                               res_o
);

  localparam int unsigned CntW = $clog2(MAX_UNIT_BYTES + 5);

  logic [23:0]     win_q, win_d;
  logic            in_body_q, in_body_d;
  logic [1:0]      pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            long_q, long_d;
  logic [7:0]      hdr_q, hdr_d;
  logic            hdr_seen_q, hdr_seen_d;
  logic            ovf_q, ovf_d;

  logic            four_end, three_end, short_code, long_code_hit;
  logic            cnt_inc;
  logic [CntW-1:0] cnt_b;
  logic [CntW-1:0] cut;
  logic [CntW-1:0] len_b;
  logic [7:0]      hbyte_b;

  logic            u_emit;
  logic [CntW-1:0] u_len;
  logic            u_over;
  logic            u_hseen;
  logic [7:0]      u_hbyte;
  logic [2:0]      u_code;
  logic            u_hdr;
  logic            u_sat;
  logic [CntW-1:0] u_len_fin;
  logic [31:0]     u_len_wide;

  assign short_code    = (win_q[15:0] == 16'd0) && (data_byte_i == START_BYTE);
  assign long_code_hit = (win_q == 24'd0) && (data_byte_i == START_BYTE);
  assign four_end      = long_code_hit;
  assign three_end     = !long_code_hit && short_code;

  assign cnt_inc = cnt_q < (limit_i + CntW'(4));
  assign cnt_b   = cnt_inc ? cnt_q + CntW'(1) : cnt_q;
  assign hbyte_b = hdr_seen_q ? hdr_q : data_byte_i;
  assign cut     = four_end ? CntW'(4) : CntW'(3);
  assign len_b   = (cnt_b >= cut) ? cnt_b - cut : '0;

  // unit result formatting
  assign u_code     = long_q ? SC_LONG : SC_SHORT;
  assign u_hdr      = u_hseen && (u_len > CntW'(u_code));
  assign u_sat      = u_over || (u_len > limit_i);
  assign u_len_fin  = u_sat ? limit_i : u_len;
  assign u_len_wide = 32'(u_len_fin);

  always_comb begin
    win_d      = win_q;
    in_body_d  = in_body_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    long_d     = long_q;
    hdr_d      = hdr_q;
    hdr_seen_d = hdr_seen_q;
    ovf_d      = ovf_q;
    u_emit     = 1'b0;
    u_len      = cnt_q;
    u_over     = ovf_q;
    u_hseen    = hdr_seen_q;
    u_hbyte    = hdr_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (operation_i == OP_EOS) begin
      u_emit    = in_body_q;
      in_body_d = 1'b0;
      pc_d      = PC_FIRST;
      win_d     = '0;
    end else if (!in_body_q) begin
      win_d = {win_q[15:0], data_byte_i};
      case (pc_q)
        PC_SHORT_CHK: begin
          if (short_code) begin
            in_body_d  = 1'b1;
            long_d     = 1'b0;
            cnt_d      = CntW'(3);
            hdr_seen_d = 1'b0;
            hdr_d      = '0;
            ovf_d      = 1'b0;
            pc_d       = PC_FIRST;
          end else begin
            pc_d = PC_LONG_CHK;
          end
        end
        PC_LONG_CHK: begin
          pc_d = PC_FIRST;
          if (long_code_hit) begin
            in_body_d  = 1'b1;
            long_d     = 1'b1;
            cnt_d      = CntW'(4);
            hdr_seen_d = 1'b0;
            hdr_d      = '0;
            ovf_d      = 1'b0;
          end else begin
            res_valid_o         = 1'b1;
            res_o.status        = ST_BAD_PREFIX;
            res_o.unit_length   = BAD_PREFIX_LEN;
            res_o.start_code_length = SC_NONE;
          end
        end
        default: begin
          pc_d = pc_q + 2'd1;
        end
      endcase
    end else begin
      win_d      = {win_q[15:0], data_byte_i};
      cnt_d      = cnt_b;
      ovf_d      = ovf_q | ~cnt_inc;
      hdr_seen_d = 1'b1;
      hdr_d      = hbyte_b;
      if (four_end || three_end) begin
        u_emit     = 1'b1;
        u_len      = len_b;
        u_over     = ovf_q | ~cnt_inc;
        u_hseen    = 1'b1;
        u_hbyte    = hbyte_b;
        long_d     = four_end;
        cnt_d      = four_end ? CntW'(4) : CntW'(3);
        hdr_seen_d = 1'b0;
        hdr_d      = '0;
        ovf_d      = 1'b0;
        pc_d       = PC_FIRST;
      end
    end

    if (u_emit) begin
      res_valid_o             = 1'b1;
      res_o.status            = ST_UNIT;
      res_o.unit_length       = u_len_wide[LEN_W-1:0];
      res_o.start_code_length = u_code;
      res_o.header_present    = u_hdr;
      res_o.f_bit             = u_hdr & u_hbyte[7];
      res_o.reference_idc     = u_hdr ? u_hbyte[6:5] : 2'd0;
      res_o.unit_type         = u_hdr ? u_hbyte[4:0] : 5'd0;
      res_o.length_overflow   = u_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      in_body_q  <= 1'b0;
      pc_q       <= PC_FIRST;
      cnt_q      <= '0;
      long_q     <= 1'b0;
      hdr_q      <= '0;
      hdr_seen_q <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (step_i) begin
      win_q      <= win_d;
      in_body_q  <= in_body_d;
      pc_q       <= pc_d;
      cnt_q      <= cnt_d;
      long_q     <= long_d;
      hdr_q      <= hdr_d;
      hdr_seen_q <= hdr_seen_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

[rtl/annexb_nal_unit_splitter.sv]
`timescale 1ns / 1ps
// Annex B byte stream splitter: takes one stream byte or end-of-stream mark per
// item and reports each unit found between start codes, with its length, start
// code length and header fields, or a bad-prefix item when no start code opens
// the stream. It takes one item every clock; an item is registered at its
// accepting edge, and the parser fills the result register from the input
// register once that can take a result. Only a stalled result stalls the
// input, and then the item behind it waits in the input register.
// Write the configuration only while the block holds no item.
module annexb_nal_unit_splitter import annexb_pkg::*; #(
  parameter int unsigned MAX_UNIT_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [16:0] unit_length_o,
  output logic [2:0]  start_code_length_o,
  output logic        header_present_o,
  output logic        f_bit_o,
  output logic [1:0]  reference_idc_o,
  output logic [4:0]  unit_type_o,
  output logic        length_overflow_o
);

  localparam int unsigned CntW       = $clog2(MAX_UNIT_BYTES + 5);
  localparam int unsigned ResetLimit = (MAX_UNIT_BYTES < 65536) ? MAX_UNIT_BYTES : 65536;

  logic [CntW-1:0] lim_q, lim_d;
  logic [31:0]     cfg_wide;
  logic [31:0]     lim_wide;

  logic            in_valid_q;
  logic            op_q;
  logic [7:0]      byte_q;
  logic            out_valid_q;
  result_t         out_q;

  logic            can_take;
  logic            step;
  logic            in_accept;
  logic            res_valid;
  result_t         res;

  // clamp the length limit at write time
  assign cfg_wide = {15'd0, cfg_wdata_i};
  assign lim_wide = (cfg_wide < 32'(MIN_LIMIT))      ? 32'(MIN_LIMIT) :
                    (cfg_wide > 32'(MAX_UNIT_BYTES)) ? 32'(MAX_UNIT_BYTES) : cfg_wide;
  assign lim_d    = lim_wide[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= CntW'(ResetLimit);
    end else if (cfg_we_i) begin
      lim_q <= lim_d;
    end
  end

  assign can_take   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && can_take;
  assign in_stall_o = in_valid_q && !can_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= operation_i;
      byte_q <= data_byte_i;
    end
  end

  annexb_parser #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .operation_i(op_q),
    .data_byte_i(byte_q),
    .limit_i    (lim_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_take) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take && step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign unit_length_o       = out_q.unit_length;
  assign start_code_length_o = out_q.start_code_length;
  assign header_present_o    = out_q.header_present;
  assign f_bit_o             = out_q.f_bit;
  assign reference_idc_o     = out_q.reference_idc;
  assign unit_type_o         = out_q.unit_type;
  assign length_overflow_o   = out_q.length_overflow;

endmodule

[rtl/annexb_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the annex b splitter, bound to the top level
module annexb_checker import annexb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        status_o,
  input logic [16:0] unit_length_o,
  input logic [2:0]  start_code_length_o,
  input logic        header_present_o,
  input logic        f_bit_o,
  input logic [1:0]  reference_idc_o,
  input logic [4:0]  unit_type_o,
  input logic        length_overflow_o
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(unit_length_o) && $stable(start_code_length_o)
      && $stable(header_present_o) && $stable(unit_type_o)
      && $stable(reference_idc_o) && $stable(f_bit_o)
      && $stable(length_overflow_o))
    else $error("result item changed while stalled");

  // bad prefix item carries fixed fields
  a_bad_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_PREFIX |-> unit_length_o == BAD_PREFIX_LEN
      && start_code_length_o == SC_NONE && !header_present_o && !length_overflow_o)
    else $error("bad prefix item malformed");

  a_code_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNIT |->
      start_code_length_o == SC_SHORT || start_code_length_o == SC_LONG)
    else $error("unit start code length out of range");

  // header fields cleared without a header byte
  a_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !header_present_o |->
      !f_bit_o && reference_idc_o == 2'd0 && unit_type_o == 5'd0)
    else $error("header fields set without header byte");

  // a unit with a header is longer than its start code
  a_header_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNIT && header_present_o |->
      unit_length_o > 17'(start_code_length_o))
    else $error("header reported in a unit without body");

endmodule

bind annexb_nal_unit_splitter annexb_checker u_checker (.*);

[verif/annexb_unit_checker.sv]
`timescale 1ns / 1ps
// checker for the annex b splitter: predicts each unit from the byte stream and compares results
module annexb_unit_checker import annexb_pkg::*; #(
  parameter int unsigned MAX_UNIT_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        status_i,
  input  logic [16:0] unit_length_i,
  input  logic [2:0]  start_code_length_i,
  input  logic        header_present_i,
  input  logic        f_bit_i,
  input  logic [1:0]  reference_idc_i,
  input  logic [4:0]  unit_type_i,
  input  logic        length_overflow_i,
  output int unsigned fail_count_o,
  output int unsigned checked_count_o,
  output int unsigned pending_o
);

  logic [16:0] limit_reg;
  logic [23:0] window_q;
  logic        in_unit_q;
  logic [1:0]  prefix_q;
  int unsigned count_q;
  logic        four_code_q;
  logic [7:0]  header_q;
  logic        header_seen_q;
  logic        overflow_q;

  result_t expected_units[$];

  function automatic int unsigned active_limit();
    int unsigned lim;
    lim = limit_reg;
    if (lim < MIN_LIMIT) lim = MIN_LIMIT;
    if (lim > MAX_UNIT_BYTES) lim = MAX_UNIT_BYTES;
    return lim;
  endfunction

  task automatic queue_unit(input int unsigned len, input logic over);
    result_t     r;
    int unsigned lim;
    int unsigned code_len;
    logic        hdr;
    lim = active_limit();
    code_len = four_code_q ? 4 : 3;
    hdr = header_seen_q && (len > code_len);
    if (over || len > lim) begin
      len = lim;
      over = 1'b1;
    end
    r.status = ST_UNIT;
    r.unit_length = len[LEN_W-1:0];
    r.start_code_length = four_code_q ? SC_LONG : SC_SHORT;
    r.header_present = hdr;
    r.f_bit = hdr ? header_q[7] : 1'b0;
    r.reference_idc = hdr ? header_q[6:5] : 2'd0;
    r.unit_type = hdr ? header_q[4:0] : 5'd0;
    r.length_overflow = over;
    expected_units.push_back(r);
  endtask

  task automatic begin_unit(input logic four);
    in_unit_q = 1'b1;
    four_code_q = four;
    count_q = four ? 4 : 3;
    header_seen_q = 1'b0;
    header_q = 8'h00;
    overflow_q = 1'b0;
    prefix_q = PC_FIRST;
  endtask

  task automatic parse_item(input logic op, input logic [7:0] b);
    result_t     bad;
    logic        four_end;
    logic        three_end;
    int unsigned cut;
    int unsigned len;
    if (op == OP_EOS) begin
      if (in_unit_q) queue_unit(count_q, overflow_q);
      in_unit_q = 1'b0;
      prefix_q = PC_FIRST;
      window_q = '0;
    end else begin
      if (!in_unit_q) begin
        if (prefix_q < PC_SHORT_CHK) begin
          prefix_q = prefix_q + 2'd1;
        end else if (prefix_q == PC_SHORT_CHK) begin
          if (window_q[15:0] == 16'h0000 && b == START_BYTE) begin_unit(1'b0);
          else prefix_q = PC_LONG_CHK;
        end else begin
          if (window_q == 24'h000000 && b == START_BYTE) begin
            begin_unit(1'b1);
          end else begin
            bad = '0;
            bad.status = ST_BAD_PREFIX;
            bad.unit_length = BAD_PREFIX_LEN;
            bad.start_code_length = SC_NONE;
            expected_units.push_back(bad);
            prefix_q = PC_FIRST;
          end
        end
      end else begin
        if (count_q < active_limit() + 4) count_q++;
        else overflow_q = 1'b1;
        if (!header_seen_q) begin
          header_seen_q = 1'b1;
          header_q = b;
        end
        four_end = (window_q == 24'h000000) && (b == START_BYTE);
        three_end = !four_end && (window_q[15:0] == 16'h0000) && (b == START_BYTE);
        if (four_end || three_end) begin
          cut = four_end ? 4 : 3;
          len = (count_q >= cut) ? count_q - cut : 0;
          queue_unit(len, overflow_q);
          begin_unit(four_end);
        end
      end
      window_q = {window_q[15:0], b};
    end
  endtask

  task automatic check_field(input string name, input logic [16:0] want, input logic [16:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_unit();
    result_t want;
    if (expected_units.size() == 0) begin
      $error("unexpected result: status %0d unit_length %0d", status_i, unit_length_i);
      fail_count_o++;
    end else begin
      want = expected_units.pop_front();
      checked_count_o++;
      check_field("status", want.status, status_i);
      check_field("unit_length", want.unit_length, unit_length_i);
      check_field("start_code_length", want.start_code_length, start_code_length_i);
      check_field("header_present", want.header_present, header_present_i);
      check_field("f_bit", want.f_bit, f_bit_i);
      check_field("reference_idc", want.reference_idc, reference_idc_i);
      check_field("unit_type", want.unit_type, unit_type_i);
      check_field("length_overflow", want.length_overflow, length_overflow_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_reg = 17'h10000;
      window_q = '0;
      in_unit_q = 1'b0;
      prefix_q = PC_FIRST;
      count_q = 0;
      four_code_q = 1'b0;
      header_q = 8'h00;
      header_seen_q = 1'b0;
      overflow_q = 1'b0;
      expected_units.delete();
      fail_count_o = 0;
      checked_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) parse_item(operation_i, data_byte_i);
      if (out_valid_i && !out_stall_i) check_unit();
      pending_o <= expected_units.size();
    end
  end

endmodule

[verif/annexb_nal_unit_splitter_tb.sv]
`timescale 1ns / 1ps
// testbench top for the annex b splitter: stream stimulus, idle patterns and verdict
module annexb_nal_unit_splitter_tb;
  import annexb_pkg::*;

  localparam int unsigned MAX_UNIT_BYTES  = 65536;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DRAIN_LIMIT     = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned NUM_PHASES      = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        operation_i = OP_BYTE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        status_o;
  logic [16:0] unit_length_o;
  logic [2:0]  start_code_length_o;
  logic        header_present_o;
  logic        f_bit_o;
  logic [1:0]  reference_idc_o;
  logic [4:0]  unit_type_o;
  logic        length_overflow_o;

  int unsigned fail_count;
  int unsigned checked_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned stream_limit  = MAX_UNIT_BYTES;

  annexb_nal_unit_splitter #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .unit_length_o      (unit_length_o),
    .start_code_length_o(start_code_length_o),
    .header_present_o   (header_present_o),
    .f_bit_o            (f_bit_o),
    .reference_idc_o    (reference_idc_o),
    .unit_type_o        (unit_type_o),
    .length_overflow_o  (length_overflow_o)
  );

  annexb_unit_checker #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
  ) i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .operation_i        (operation_i),
    .data_byte_i        (data_byte_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_i           (status_o),
    .unit_length_i      (unit_length_o),
    .start_code_length_i(start_code_length_o),
    .header_present_i   (header_present_o),
    .f_bit_i            (f_bit_o),
    .reference_idc_i    (reference_idc_o),
    .unit_type_i        (unit_type_o),
    .length_overflow_i  (length_overflow_o),
    .fail_count_o       (fail_count),
    .checked_count_o    (checked_count),
    .pending_o          (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_start_code(input logic four);
    if (four) send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, START_BYTE);
  endtask

  // zeros and start bytes often, so partial and hidden start codes show up
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(4))
      0, 1:    return 8'h00;
      2:       return START_BYTE;
      default: return 8'($urandom());
    endcase
  endfunction

  // wait for every expected result, then let the pipeline empty
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [16:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stream_limit = value;
    if (stream_limit < MIN_LIMIT) stream_limit = MIN_LIMIT;
    if (stream_limit > MAX_UNIT_BYTES) stream_limit = MAX_UNIT_BYTES;
  endtask

  task automatic send_random_stream(input int unsigned target);
    int unsigned first;
    int unsigned pick;
    int unsigned body_len;
    int unsigned max_body;
    logic [7:0]  miss;
    first = items_sent;
    max_body = (stream_limit > 64) ? 24 : stream_limit + 6;
    while (items_sent - first < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_start_code(1'($urandom_range(1)));
        if ($urandom_range(9) != 0) begin
          send_item(OP_BYTE, 8'($urandom()));
          body_len = ($urandom_range(5) == 0) ? $urandom_range(max_body) : $urandom_range(10);
          repeat (body_len) begin
            send_item(OP_BYTE, ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom()));
          end
        end
        if ($urandom_range(4) == 0) send_item(OP_EOS, 8'($urandom()));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) send_item(OP_BYTE, noise_byte());
      end else begin
        // broken start code after end of stream
        send_item(OP_EOS, 8'($urandom()));
        miss = 8'($urandom_range(2, 255));
        case ($urandom_range(2))
          0: begin
            send_item(OP_BYTE, 8'h00);
            send_item(OP_BYTE, 8'h00);
            send_item(OP_BYTE, miss);
            send_item(OP_BYTE, 8'($urandom()));
          end
          1: begin
            send_item(OP_BYTE, 8'h00);
            send_item(OP_BYTE, 8'h00);
            send_item(OP_BYTE, 8'h00);
            send_item(OP_BYTE, ($urandom_range(1) == 0) ? 8'h00 : miss);
          end
          default: begin
            repeat ($urandom_range(1, 3)) send_item(OP_BYTE, 8'h00);
            send_item(OP_EOS, 8'($urandom()));
          end
        endcase
      end
    end
  endtask

  initial begin
    logic [16:0] limit_values[NUM_PHASES];
    limit_values = '{17'd5, 17'd65536, 17'd0, 17'd12, 17'd131071, 17'd40, 17'd6, 17'd20};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // end of stream while seeking, then a prefix that fails on its fourth byte
    send_item(OP_EOS, 8'hff);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'h07);
    // long code, all-ones header, ended by a short code
    send_start_code(1'b1);
    send_item(OP_BYTE, 8'hff);
    send_start_code(1'b0);
    // all-zero header, ended by a long code
    send_item(OP_BYTE, 8'h00);
    send_start_code(1'b1);
    // no header: next code follows at once, then end of stream right after a code
    send_start_code(1'b0);
    send_item(OP_EOS, 8'h00);
    send_start_code(1'b0);
    send_item(OP_BYTE, 8'h61);
    send_item(OP_EOS, 8'h5a);
    // partial prefix dropped by end of stream
    send_item(OP_BYTE, 8'h00);
    send_item(OP_EOS, 8'h00);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_limit(limit_values[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct = 24;
        end
      endcase
      send_random_stream(ITEMS_PER_PHASE);
    end

    drain_results();
    $display("run covered %0d stream items and %0d checked results", items_sent, checked_count);
    $display("over %0d limit settings and four idle and stall patterns", NUM_PHASES + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/annexb_pkg.sv
rtl/annexb_parser.sv
rtl/annexb_nal_unit_splitter.sv
rtl/annexb_checker.sv
verif/annexb_unit_checker.sv
verif/annexb_nal_unit_splitter_tb.sv
